[rtl/core/soft_knee_peak_limiter_macros.svh]
// Assertion macros for the soft-knee peak limiter.
// Used by files that carry concurrent checks; no other dependencies.
`ifndef SOFT_KNEE_PEAK_LIMITER_MACROS_SVH
`define SOFT_KNEE_PEAK_LIMITER_MACROS_SVH
`ifndef SYNTHESIS
// check gated off while reset is active
`define SKPL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also runs during reset
`define SKPL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SKPL_ASSERT(lbl, clk, rst_n, prop, msg)
`define SKPL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[rtl/core/skpl_pkg.sv]
// Shared constants and controller/datapath interface types for the limiter.
// No dependencies.
package skpl_pkg;

    localparam int SAMPLE_W         = 16;
    localparam int THR_W            = 15;
    localparam int MAG_W            = 17;
    localparam int QUOT_W           = 17;
    localparam int DIV_STEPS        = 17;
    localparam int CNT_W            = 5;
    localparam int TANH_ENTRIES_DEF = 256;

    localparam logic [THR_W-1:0] KNEE_MIN     = 15'd16384;
    localparam logic [THR_W-1:0] KNEE_MAX     = 15'd32440;
    localparam logic [THR_W-1:0] THRESH_RESET = 15'd29491;

    // controller -> datapath commands
    typedef struct packed {
        logic load;      // capture a new sample, update peak
        logic div_step;  // one restoring divide step
        logic map;       // ratio -> table position
        logic rd;        // table read
        logic interp;    // linear interpolation
        logic mul;       // scale by headroom
        logic fin;       // load output register
    } t_dp_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic over_knee; // captured sample lies above the knee
    } t_dp_sts;

endpackage

[rtl/core/soft_knee_peak_limiter.sv]
// Soft-knee tanh peak limiter with running peak meter.
//
// Input stream: i_s_tdata carries one signed Q1.15 sample, i_s_tlast marks
// the last sample of a buffer. Output stream: o_m_tdata carries the limited
// sample in bits 15:0 and the buffer peak magnitude in bits 31:16; o_m_tlast
// copies the input mark, and the peak on that transaction is final for the
// buffer (the meter restarts from zero afterwards).
// The knee register is written through i_cfg_we/i_cfg_wdata; the user must write it
// only while idle, as the block does not enforce this. It is clamped internally to 0.5..0.99.
// A sample at or below the knee goes from the check straight to the output
// register; one above it first passes the restoring divider that forms
// overage/headroom, then the table map and read, interpolation and scaling. One
// item is in flight at a time: a new transaction is taken only once the last is done.
// The output register holds a finished result while the next sample is
// accepted and processed; a stalled receiver only holds the block at the last
// step of the following item.
// Reset (synchronous, active low): knee returns to 29491, peak to zero,
// output empty, input ready.
// Depends on skpl_pkg, skpl_ctrl, skpl_dp and the assertion macro header.
`include "soft_knee_peak_limiter_macros.svh"

module soft_knee_peak_limiter #(
    parameter int TANH_ENTRIES = skpl_pkg::TANH_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [14:0] i_cfg_wdata,   // threshold
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,     // [15:0] in_sample
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,     // [15:0] out_sample, [31:16] peak_level
    output logic        o_m_tlast
);

    skpl_pkg::t_dp_cmd cmd;
    skpl_pkg::t_dp_sts sts;
    logic [15:0]       out_sample;
    logic [15:0]       out_peak;

    skpl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    skpl_dp #(
        .TANH_ENTRIES (TANH_ENTRIES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_sample     (i_s_tdata),
        .i_last       (i_s_tlast),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_out_sample (out_sample),
        .o_out_peak   (out_peak),
        .o_out_last   (o_m_tlast)
    );

    assign o_m_tdata = {out_peak, out_sample};

    // checks
    `SKPL_ASSERT_ALWAYS(a_reset_state, i_clk, !i_rst_n |=> o_s_tready && !o_m_tvalid, "block not idle after reset")
    `SKPL_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_s_tvalid && o_s_tready |=> !o_s_tready, "accepted a second transaction while busy")
    `SKPL_ASSERT(a_one_cmd, i_clk, i_rst_n, $onehot0({cmd.div_step, cmd.map, cmd.rd, cmd.interp, cmd.mul, cmd.fin}), "overlapping datapath commands")
    `SKPL_ASSERT(a_peak_range, i_clk, i_rst_n, o_m_tvalid |-> o_m_tdata[31:16] <= 16'd32768, "peak level out of range")

endmodule

[rtl/core/skpl_ctrl.sv]
// Sequencer for the limiter: handshakes and datapath step control.
// Depends on skpl_pkg.
module skpl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    input  skpl_pkg::t_dp_sts i_sts,
    output skpl_pkg::t_dp_cmd o_cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHK    = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_MAP    = 3'd3;
    localparam logic [2:0] ST_RD     = 3'd4;
    localparam logic [2:0] ST_INTERP = 3'd5;
    localparam logic [2:0] ST_MUL    = 3'd6;
    localparam logic [2:0] ST_FIN    = 3'd7;

    localparam logic [skpl_pkg::CNT_W-1:0] CNT_LAST =
        skpl_pkg::CNT_W'(skpl_pkg::DIV_STEPS - 1);

    logic [2:0]                 r_state, n_state;
    logic [skpl_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                       r_m_valid, n_m_valid;
    logic                       s_fire;
    logic                       fin_ok;

    assign s_fire = i_s_tvalid && (r_state == ST_IDLE);
    assign fin_ok = !r_m_valid || i_m_tready;

    // next state and divide step count
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (s_fire) begin
                    n_state = ST_CHK;
                end
            end
            ST_CHK: begin
                n_cnt   = '0;
                n_state = i_sts.over_knee ? ST_DIV : ST_FIN;
            end
            ST_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_MAP;
                end
            end
            ST_MAP:    n_state = ST_RD;
            ST_RD:     n_state = ST_INTERP;
            ST_INTERP: n_state = ST_MUL;
            ST_MUL:    n_state = ST_FIN;
            ST_FIN: begin
                if (fin_ok) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // output valid: set when a result lands, cleared when taken
    always_comb begin
        n_m_valid = r_m_valid;
        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end
        if ((r_state == ST_FIN) && fin_ok) begin
            n_m_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_m_valid <= n_m_valid;
        end
    end

    // command decode
    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = s_fire;
        o_cmd.div_step = (r_state == ST_DIV);
        o_cmd.map      = (r_state == ST_MAP);
        o_cmd.rd       = (r_state == ST_RD);
        o_cmd.interp   = (r_state == ST_INTERP);
        o_cmd.mul      = (r_state == ST_MUL);
        o_cmd.fin      = (r_state == ST_FIN) && fin_ok;
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_m_valid;

endmodule

[rtl/core/skpl_dp.sv]
// Datapath for the limiter: knee clamp, peak tracking, serial divider,
// tanh table with interpolation, headroom scaling. Depends on skpl_pkg.
module skpl_dp #(
    parameter int TANH_ENTRIES = skpl_pkg::TANH_ENTRIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [skpl_pkg::THR_W-1:0]      i_cfg_wdata,
    input  logic [skpl_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic                            i_last,
    input  skpl_pkg::t_dp_cmd               i_cmd,
    output skpl_pkg::t_dp_sts               o_sts,
    output logic [skpl_pkg::SAMPLE_W-1:0]   o_out_sample,
    output logic [skpl_pkg::SAMPLE_W-1:0]   o_out_peak,
    output logic                            o_out_last
);

    localparam int IDX_W    = $clog2(TANH_ENTRIES);
    localparam int TANH_DEN = TANH_ENTRIES - 1;
    localparam int PROD_W   = skpl_pkg::QUOT_W + IDX_W;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    typedef logic [15:0] t_tanh_rom [TANH_ENTRIES];

    // shift-and-subtract quotient, used only while building the table
    function automatic logic [63:0] udiv_u64(input logic [63:0] num, input logic [63:0] dvs);
        logic [63:0] q, r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= dvs) begin
                r    = r - dvs;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // one table entry: odd series at a sixteenth of the argument, then four
    // double-angle steps, rounded to Q1.15
    function automatic logic [15:0] tanh_entry(input int unsigned k);
        logic [63:0] x, a, a2, a3, a5, a7, a9, t, den;
        x  = udiv_u64(64'(k) << 31, 64'(TANH_DEN));
        a  = x >> 4;
        a2 = (a * a) >> 30;
        a3 = (a * a2) >> 30;
        a5 = (a3 * a2) >> 30;
        a7 = (a5 * a2) >> 30;
        a9 = (a7 * a2) >> 30;
        t  = a + (64'd2 * a5) / 64'd15 + (64'd62 * a9) / 64'd2835
             - a3 / 64'd3 - (64'd17 * a7) / 64'd315;
        for (int i = 0; i < 4; i++) begin
            den = ONE_Q30 + ((t * t) >> 30);
            t   = udiv_u64(t << 31, den);
        end
        t = (t + 64'd16384) >> 15;
        if (t > 64'd32768) begin
            t = 64'd32768;
        end
        return t[15:0];
    endfunction

    function automatic t_tanh_rom build_rom();
        t_tanh_rom rom;
        for (int k = 0; k < TANH_ENTRIES; k++) begin
            rom[k] = tanh_entry(k);
        end
        return rom;
    endfunction

    localparam t_tanh_rom TANH_ROM = build_rom();

    logic [skpl_pkg::THR_W-1:0]    r_threshold;
    logic [skpl_pkg::SAMPLE_W-1:0] r_peak, n_peak;
    logic [skpl_pkg::SAMPLE_W-1:0] r_sample;
    logic                          r_last;
    logic [skpl_pkg::THR_W-1:0]    r_knee, knee_c;
    logic [skpl_pkg::THR_W-1:0]    r_head;
    logic                          r_over_knee;
    logic [15:0]                   r_rem;
    logic [skpl_pkg::QUOT_W-1:0]   r_quot;
    logic [IDX_W-1:0]              r_idx;
    logic [15:0]                   r_frac;
    logic [15:0]                   r_lo, r_hi;
    logic [16:0]                   r_tanh;
    logic [16:0]                   r_comp;
    logic [skpl_pkg::SAMPLE_W-1:0] r_out_sample, r_out_peak;
    logic [skpl_pkg::SAMPLE_W-1:0] r_out_peak_hold;
    logic                          r_out_last;

    logic [skpl_pkg::MAG_W-1:0]    mag;
    logic [skpl_pkg::THR_W-1:0]    over;
    logic [15:0]                   rem_sub;
    logic                          q_bit;
    logic [PROD_W-1:0]             n_prod, n_pos;
    logic [IDX_W-1:0]              n_idx_hi;
    logic [15:0]                   n_diff;
    logic [31:0]                   n_ip;
    logic [32:0]                   n_ipr;
    logic [16:0]                   n_tanh;
    logic [31:0]                   n_mp;
    logic [32:0]                   n_mpr;
    logic [16:0]                   n_y;
    logic [skpl_pkg::SAMPLE_W-1:0] n_out_sample;

    // knee clamp
    always_comb begin
        knee_c = r_threshold;
        if (r_threshold < skpl_pkg::KNEE_MIN) begin
            knee_c = skpl_pkg::KNEE_MIN;
        end else if (r_threshold > skpl_pkg::KNEE_MAX) begin
            knee_c = skpl_pkg::KNEE_MAX;
        end
    end

    // magnitude, overage and running peak
    assign mag    = i_sample[15] ? (17'h10000 - {1'b0, i_sample}) : {1'b0, i_sample};
    assign over   = skpl_pkg::THR_W'(mag - {2'b00, knee_c});
    assign n_peak = (mag[15:0] > r_peak) ? mag[15:0] : r_peak;

    // threshold register and peak state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= skpl_pkg::THRESH_RESET;
            r_peak      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_threshold <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_peak <= i_last ? '0 : n_peak;
            end
        end
    end

    // restoring divide step: one quotient bit per cycle
    assign q_bit   = (r_rem >= {1'b0, r_head});
    assign rem_sub = q_bit ? (r_rem - {1'b0, r_head}) : r_rem;

    // ratio to table position
    assign n_prod   = PROD_W'(r_quot) * PROD_W'(TANH_DEN);
    assign n_pos    = n_prod >> 1;
    assign n_idx_hi = r_idx + IDX_W'(1);

    // interpolation between neighboring entries
    assign n_diff = (r_hi >= r_lo) ? (r_hi - r_lo) : 16'd0;
    assign n_ip   = n_diff * r_frac;
    assign n_ipr  = {1'b0, n_ip} + 33'd32768;
    assign n_tanh = {1'b0, r_lo} + n_ipr[32:16];

    // scale back by headroom, round half up
    assign n_mp  = 32'(r_tanh) * 32'(r_head);
    assign n_mpr = {1'b0, n_mp} + 33'd16384;

    // final sum, saturation and sign
    assign n_y = 17'(r_knee) + r_comp;
    always_comb begin
        n_out_sample = r_sample;
        if (r_over_knee) begin
            if (r_sample[15]) begin
                n_out_sample = (n_y > 17'd32768) ? 16'h8000 : 16'(17'h10000 - n_y);
            end else begin
                n_out_sample = (n_y > 17'd32767) ? 16'h7FFF : n_y[15:0];
            end
        end
    end

    // payload pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample    <= i_sample;
            r_last      <= i_last;
            r_knee      <= knee_c;
            r_head      <= skpl_pkg::THR_W'(16'h8000 - {1'b0, knee_c});
            r_over_knee <= (mag > {2'b00, knee_c});
            r_rem       <= {1'b0, over};
            r_quot      <= '0;
            r_out_peak  <= n_peak;
        end
        if (i_cmd.div_step) begin
            r_rem  <= {rem_sub[14:0], 1'b0};
            r_quot <= {r_quot[skpl_pkg::QUOT_W-2:0], q_bit};
        end
        if (i_cmd.map) begin
            r_idx  <= n_pos[16 +: IDX_W];
            r_frac <= n_pos[15:0];
        end
        if (i_cmd.rd) begin
            r_lo <= TANH_ROM[r_idx];
            r_hi <= TANH_ROM[n_idx_hi];
        end
        if (i_cmd.interp) begin
            r_tanh <= n_tanh;
        end
        if (i_cmd.mul) begin
            r_comp <= n_mpr[31:15];
        end
        if (i_cmd.fin) begin
            r_out_sample <= n_out_sample;
            r_out_last   <= r_last;
        end
    end

    // peak of the delivered result is the one captured with its sample
    assign o_sts.over_knee = r_over_knee;
    assign o_out_sample    = r_out_sample;
    assign o_out_peak      = r_out_peak_hold;

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_out_peak_hold <= r_out_peak;
        end
    end

    assign o_out_last = r_out_last;

endmodule

[bench/limiter_checker.sv]
// Checker for the soft-knee peak limiter: watches the config, input and output channels,
// predicts each limited sample and buffer peak, and counts mismatches.
// Depends on skpl_pkg for the knee limits and the reset knee.
`timescale 1ns / 100ps

module limiter_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [14:0] i_cfg_wdata,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] in_sample
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,   // [15:0] out_sample, [31:16] peak_level
    input  logic        i_m_tlast,
    output int          o_pending,
    output int          o_fail_count
);

    localparam int          TANH_POINTS = skpl_pkg::TANH_ENTRIES_DEF;
    localparam bit [63:0]   Q30_ONE     = 64'd1 << 30;

    typedef struct packed {
        logic [15:0] sample;
        logic [15:0] peak;
        logic        last;
    } t_limiter_out;

    t_limiter_out  limited_queue[$];
    bit [15:0]     tanh_curve[TANH_POINTS];
    logic [14:0]   knee_reg;
    logic [16:0]   peak_meter;

    // one tanh table point: series at a sixteenth of the argument, then four doublings
    function automatic bit [15:0] tanh_point(int unsigned k);
        bit [63:0] x, a, a2, a3, a5, a7, a9, t, den;
        x  = (64'(k) << 31) / 64'(TANH_POINTS - 1);
        a  = x >> 4;
        a2 = (a * a) >> 30;
        a3 = (a * a2) >> 30;
        a5 = (a3 * a2) >> 30;
        a7 = (a5 * a2) >> 30;
        a9 = (a7 * a2) >> 30;
        t  = a + (64'd2 * a5) / 64'd15 + (64'd62 * a9) / 64'd2835
             - a3 / 64'd3 - (64'd17 * a7) / 64'd315;
        for (int i = 0; i < 4; i++) begin
            den = Q30_ONE + ((t * t) >> 30);
            t   = (t << 31) / den;
        end
        t = (t + 64'd16384) >> 15;
        if (t > 64'd32768)
            t = 64'd32768;
        return t[15:0];
    endfunction

    // interpolated tanh of a Q16 ratio, saturating past the table
    function automatic bit [16:0] tanh_of_ratio(bit [16:0] ratio);
        bit [63:0] pos, idx, frac;
        bit [16:0] lo, hi;
        pos  = (64'(ratio) * 64'(TANH_POINTS - 1)) >> 1;
        idx  = pos >> 16;
        frac = 64'(pos[15:0]);
        if (idx >= 64'(TANH_POINTS - 1)) begin
            if (idx == 64'(TANH_POINTS - 1) && frac == 64'd0)
                return 17'(tanh_curve[TANH_POINTS - 1]);
            return 17'd32768;
        end
        lo = 17'(tanh_curve[idx]);
        hi = 17'(tanh_curve[idx + 1]);
        if (hi < lo)
            hi = lo;
        return lo + 17'((64'(hi - lo) * frac + 64'd32768) >> 16);
    endfunction

    // soft-knee limiting of one sample against the clamped knee
    function automatic logic [15:0] predict_limited(logic [15:0] raw, logic [14:0] thr);
        bit [16:0] mag, knee, head, over, ratio, tv, y;
        bit [63:0] comp;
        mag  = raw[15] ? 17'h10000 - 17'(raw) : 17'(raw);
        knee = 17'(thr);
        if (knee < 17'(skpl_pkg::KNEE_MIN))
            knee = 17'(skpl_pkg::KNEE_MIN);
        if (knee > 17'(skpl_pkg::KNEE_MAX))
            knee = 17'(skpl_pkg::KNEE_MAX);
        if (mag <= knee)
            return raw;
        head  = 17'd32768 - knee;
        over  = mag - knee;
        ratio = 17'((64'(over) << 16) / 64'(head));
        tv    = tanh_of_ratio(ratio);
        comp  = (64'(tv) * 64'(head) + 64'd16384) >> 15;
        y     = knee + 17'(comp);
        if (raw[15]) begin
            if (y > 17'd32768)
                y = 17'd32768;
            return 16'(17'h10000 - y);
        end
        if (y > 17'd32767)
            y = 17'd32767;
        return y[15:0];
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        knee_reg     = skpl_pkg::THRESH_RESET;
        peak_meter   = '0;
        for (int k = 0; k < TANH_POINTS; k++)
            tanh_curve[k] = tanh_point(k);
    end

    always @(posedge i_clk) begin
        t_limiter_out got, want;
        logic [16:0]  mag;
        if (!i_rst_n) begin
            knee_reg   = skpl_pkg::THRESH_RESET;
            peak_meter = '0;
            limited_queue.delete();
        end else begin
            // output transaction: compare against the oldest prediction
            if (i_m_tvalid && i_m_tready) begin
                got = '{sample: i_m_tdata[15:0], peak: i_m_tdata[31:16], last: i_m_tlast};
                if (limited_queue.size() == 0) begin
                    report_mismatch("unexpected output transaction", int'(got.sample), 0);
                end else begin
                    want = limited_queue.pop_front();
                    if (got.sample !== want.sample)
                        report_mismatch("out_sample", int'($signed(got.sample)),
                                        int'($signed(want.sample)));
                    if (got.peak !== want.peak)
                        report_mismatch("peak_level", int'(got.peak), int'(want.peak));
                    if (got.last !== want.last)
                        report_mismatch("last", int'(got.last), int'(want.last));
                end
            end
            // input transaction: update the meter and queue the prediction
            if (i_s_tvalid && i_s_tready) begin
                mag = i_s_tdata[15] ? 17'h10000 - 17'(i_s_tdata) : 17'(i_s_tdata);
                if (mag > peak_meter)
                    peak_meter = mag;
                want.sample = predict_limited(i_s_tdata, knee_reg);
                want.peak   = peak_meter[15:0];
                want.last   = i_s_tlast;
                limited_queue.push_back(want);
                if (i_s_tlast)
                    peak_meter = '0;
            end
            if (i_cfg_we)
                knee_reg = i_cfg_wdata;
        end
        o_pending = limited_queue.size();
    end

endmodule

[bench/testbench.sv]
// Top of the limiter bench: clock, reset, config writes, sample stimulus and output
// back-pressure; the verdict comes from the failure count of limiter_checker.
// Depends on soft_knee_peak_limiter, limiter_checker and skpl_pkg.
`timescale 1ns / 100ps

module testbench;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 30;
    localparam int PHASE_ITEMS  = 90;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [14:0] i_cfg_wdata;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;
    logic        i_s_tlast;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;
    logic        o_m_tlast;

    int          pending;
    int          fail_count;
    int unsigned cycle_count;
    int          idle_pct;
    int          stall_pct;
    logic [14:0] knee_now;

    soft_knee_peak_limiter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    limiter_checker u_limiter_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tlast    (i_s_tlast),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tlast    (o_m_tlast),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always #6 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver back-pressure
    always @(negedge i_clk)
        i_m_tready <= ($urandom_range(99) >= stall_pct);

    // one input transaction, with random idle cycles ahead of it; entered at a falling edge
    task automatic send_sample(input logic [15:0] sample, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= sample;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    // drop valid, let all predicted outputs arrive, then let the datapath settle
    task automatic wait_for_drain();
        i_s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_knee(input logic [14:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        knee_now     = value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    // random sample, weighted toward the knee and large magnitudes
    function automatic logic [15:0] pick_sample();
        int knee, mag;
        bit neg;
        knee = knee_now;
        if (knee < skpl_pkg::KNEE_MIN) knee = skpl_pkg::KNEE_MIN;
        if (knee > skpl_pkg::KNEE_MAX) knee = skpl_pkg::KNEE_MAX;
        neg = $urandom_range(1);
        case ($urandom_range(9))
            0, 1, 2: return 16'($urandom);
            3, 4, 5: mag = knee + $urandom_range(80) - 40;
            6, 7:    mag = $urandom_range(32768, knee);
            8: begin
                case ($urandom_range(4))
                    0: return 16'h7FFF;
                    1: return 16'h8000;
                    2: return 16'h0000;
                    3: return 16'hFFFF;
                    default: return 16'h0001;
                endcase
            end
            default: mag = $urandom_range(2048);
        endcase
        if (mag < 0) mag = 0;
        if (mag >= 32768) begin
            mag = 32768;
            neg = 1'b1;
        end
        return neg ? 16'(32'h10000 - mag) : 16'(mag);
    endfunction

    initial begin
        logic [15:0] directed[18];
        logic [14:0] knees[6];
        int          idles[6];
        int          stalls[6];

        directed = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8001,
                     16'd29491, 16'd29492, 16'(-29491), 16'(-29492), 16'h4000, 16'hC000,
                     16'd30000, 16'(-31000), 16'd32000, 16'h5555, 16'hAAAA, 16'd100};
        knees    = '{15'd0, 15'd32767, 15'd16384, 15'd32440, 15'd16383, 15'd0};
        idles    = '{56, 0, 15, 0, 56, 0};
        stalls   = '{0, 56, 15, 0, 0, 56};

        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tlast   = 1'b0;
        i_m_tready  = 1'b0;
        idle_pct    = 0;
        stall_pct   = 0;
        cycle_count = 0;
        knee_now    = skpl_pkg::THRESH_RESET;
        knees[5]    = 15'($urandom);

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed samples at the reset knee; a buffer ends right after the most negative one
        foreach (directed[i])
            send_sample(directed[i], (i == 4) || (i == 11) || (i == 17));
        wait_for_drain();

        // random phases, each with its own knee, idle and stall pattern
        foreach (knees[p]) begin
            write_knee(knees[p]);
            idle_pct  = idles[p];
            stall_pct = stalls[p];
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_sample(pick_sample(), $urandom_range(15) == 0);
            wait_for_drain();
        end

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
